/* hw/rtl/wall_run_extractor_top_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef WALL_RUN_EXTRACTOR_TOP_ASSERT_SVH
`define WALL_RUN_EXTRACTOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wall run extractor check failed");

// The consequent must hold in the cycle after the antecedent.
`define WRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wall run extractor check failed");

`endif

/* hw/rtl/wre_pkg.sv */
package wre_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 9;
    localparam int CNT_W      = 9;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN    = 2'd2;

    localparam logic [DIM_W-1:0] RST_MAP_WIDTH  = 9'd64;
    localparam logic [DIM_W-1:0] RST_MAP_HEIGHT = 9'd64;
    localparam logic [CNT_W-1:0] RST_MIN_RUN    = 9'd3;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

    typedef struct packed {
        logic             is_vertical;
        logic [DIM_W-1:0] coord_x;
        logic [DIM_W-1:0] coord_y;
        logic [CNT_W-1:0] run_length;
        logic             last_of_item;
    } t_result;

    typedef struct packed {
        logic             wall;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_end;
        logic             last_row;
        logic [CNT_W-1:0] row_cnt;
        logic             col_valid;
        logic             fwd;
    } t_tile;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } t_col_wr;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                   logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/wall_run_extractor_top.sv */
// Wall run extractor: tiles enter in raster order, one per cycle when the output keeps up.
// A tile is read against its column counter (a 256 x 9 RAM, read in the cycle of the request
// and written back in the cycle after), so its results are pushed into the 8-entry output queue
// in the cycle after acceptance and are registered there before they can be taken. The output
// delivers one result per cycle when not stalled; the input stalls whenever the queue could not
// absorb two results from the request in flight and two from a new one.
// Writing map_width or map_height restarts the frame at once, with no clearing pass.
module wall_run_extractor_top
    import wre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_is_wall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_is_vertical,
    output logic [DIM_W-1:0]     o_coord_x,
    output logic [DIM_W-1:0]     o_coord_y,
    output logic [CNT_W-1:0]     o_run_length,
    output logic                 o_last_of_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0] r_map_width;
    logic [DIM_W-1:0] r_map_height;
    logic [CNT_W-1:0] r_min_run;

    logic                  cfg_write;
    logic                  geom_clear;
    logic                  accept;
    logic [DIM_W-1:0]      width_eff;
    logic [DIM_W-1:0]      height_eff;
    logic [COL_W-1:0]      rd_addr;
    logic [CNT_W-1:0]      rd_data;
    logic                  tile_valid;
    t_tile                 tile;
    t_col_wr               col_wr;
    t_push                 push;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0]   q_need;
    t_result               result;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign geom_clear  = cfg_write &&
                         (i_cfg_index == REG_MAP_WIDTH || i_cfg_index == REG_MAP_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= RST_MAP_WIDTH;
            r_map_height <= RST_MAP_HEIGHT;
            r_min_run    <= RST_MIN_RUN;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                REG_MIN_RUN:    r_min_run    <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign width_eff  = clamp_dim(r_map_width, DIM_W'(MAX_WIDTH));
    assign height_eff = clamp_dim(r_map_height, DIM_W'(MAX_HEIGHT));

    // Room for two results from the request in flight and two from a new one.
    assign q_need     = (OUTQ_CNT_W + 1)'(q_count)
                      + ((OUTQ_CNT_W + 1)'(tile_valid) << 1)
                      + (OUTQ_CNT_W + 1)'(2);
    assign o_in_stall = q_need > (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    wre_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_is_wall    (i_is_wall),
        .i_clear      (geom_clear),
        .i_width      (width_eff),
        .i_height     (height_eff),
        .i_col_wr     (col_wr),
        .o_rd_addr    (rd_addr),
        .o_tile_valid (tile_valid),
        .o_tile       (tile)
    );

    wre_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (col_wr.en),
        .i_wr_addr (col_wr.addr),
        .i_wr_data (col_wr.data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    wre_run u_run (
        .i_clk        (i_clk),
        .i_tile_valid (tile_valid),
        .i_tile       (tile),
        .i_rd_data    (rd_data),
        .i_min_run    (r_min_run),
        .o_col_wr     (col_wr),
        .o_push       (push)
    );

    wre_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_stall  (i_out_stall),
        .o_count  (q_count),
        .o_valid  (o_out_valid),
        .o_result (result)
    );

    assign o_is_vertical  = result.is_vertical;
    assign o_coord_x      = result.coord_x;
    assign o_coord_y      = result.coord_y;
    assign o_run_length   = result.run_length;
    assign o_last_of_item = result.last_of_item;

endmodule

/* hw/rtl/wre_ram.sv */
module wre_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/wre_scan.sv */
module wre_scan
    import wre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_is_wall,
    input  logic             i_clear,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  t_col_wr          i_col_wr,
    output logic [COL_W-1:0] o_rd_addr,
    output logic             o_tile_valid,
    output t_tile            o_tile
);

    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [CNT_W-1:0]     r_row_cnt;
    logic [MAX_WIDTH-1:0] r_col_valid;
    logic                 r_tile_valid;
    t_tile                r_tile;

    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [CNT_W-1:0] n_row_cnt;
    logic             row_end;
    logic             last_row;
    t_tile            n_tile;

    always_comb begin
        row_end  = (DIM_W'(r_col) + DIM_W'(1)) >= i_width;
        last_row = (DIM_W'(r_row) + DIM_W'(1)) >= i_height;

        if (i_is_wall && !row_end) begin
            n_row_cnt = r_row_cnt + CNT_W'(1);
        end else begin
            n_row_cnt = '0;
        end

        if (row_end) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end

        n_tile.wall      = i_is_wall;
        n_tile.col       = r_col;
        n_tile.row       = r_row;
        n_tile.row_end   = row_end;
        n_tile.last_row  = last_row;
        n_tile.row_cnt   = r_row_cnt;
        n_tile.col_valid = r_col_valid[r_col];
        // The counter written back this cycle is not yet visible in the RAM read.
        n_tile.fwd       = i_col_wr.en && (i_col_wr.addr == r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col       <= '0;
            r_row       <= '0;
            r_row_cnt   <= '0;
            r_col_valid <= '0;
        end else begin
            if (i_accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_row_cnt <= n_row_cnt;
            end
            if (i_col_wr.en) begin
                r_col_valid[i_col_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_valid <= 1'b0;
        end else begin
            r_tile_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tile <= n_tile;
        end
    end

    assign o_rd_addr    = r_col;
    assign o_tile_valid = r_tile_valid;
    assign o_tile       = r_tile;

endmodule

/* hw/rtl/wre_run.sv */
module wre_run
    import wre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_tile_valid,
    input  t_tile            i_tile,
    input  logic [CNT_W-1:0] i_rd_data,
    input  logic [CNT_W-1:0] i_min_run,
    output t_col_wr          o_col_wr,
    output t_push            o_push
);

    logic [CNT_W-1:0] r_last_wr;

    logic [CNT_W-1:0] need;
    logic [DIM_W-1:0] x_next;
    logic [DIM_W-1:0] y_next;
    logic [CNT_W-1:0] col_cnt;
    logic [CNT_W-1:0] h_len;
    logic [DIM_W-1:0] h_x;
    logic             h_fire;
    logic             h_ok;
    logic [CNT_W-1:0] v_len;
    logic [DIM_W-1:0] v_y;
    logic             v_fire;
    logic             v_ok;
    logic [CNT_W-1:0] wr_data;
    t_result          h_res;
    t_result          v_res;

    always_comb begin
        need   = (i_min_run == '0) ? CNT_W'(1) : i_min_run;
        x_next = DIM_W'(i_tile.col) + DIM_W'(1);
        y_next = DIM_W'(i_tile.row) + DIM_W'(1);

        if (i_tile.fwd) begin
            col_cnt = r_last_wr;
        end else if (i_tile.col_valid) begin
            col_cnt = i_rd_data;
        end else begin
            col_cnt = '0;
        end

        if (i_tile.wall) begin
            h_len  = i_tile.row_cnt + CNT_W'(1);
            h_x    = x_next;
            h_fire = i_tile.row_end;
            v_len  = col_cnt + CNT_W'(1);
            v_y    = y_next;
            v_fire = i_tile.last_row;
            wr_data = i_tile.last_row ? '0 : v_len;
        end else begin
            h_len  = i_tile.row_cnt;
            h_x    = DIM_W'(i_tile.col);
            h_fire = i_tile.row_cnt != '0;
            v_len  = col_cnt;
            v_y    = DIM_W'(i_tile.row);
            v_fire = col_cnt != '0;
            wr_data = '0;
        end

        h_ok = i_tile_valid && h_fire && (h_len >= need);
        v_ok = i_tile_valid && v_fire && (v_len >= need);

        h_res.is_vertical  = 1'b0;
        h_res.coord_x      = h_x;
        h_res.coord_y      = y_next;
        h_res.run_length   = h_len;
        h_res.last_of_item = !v_ok;

        v_res.is_vertical  = 1'b1;
        v_res.coord_x      = x_next;
        v_res.coord_y      = v_y;
        v_res.run_length   = v_len;
        v_res.last_of_item = 1'b1;

        o_push.num    = {h_ok && v_ok, h_ok ^ v_ok};
        o_push.first  = h_ok ? h_res : v_res;
        o_push.second = v_res;

        o_col_wr.en   = i_tile_valid;
        o_col_wr.addr = i_tile.col;
        o_col_wr.data = wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_tile_valid) begin
            r_last_wr <= wr_data;
        end
    end

endmodule

/* hw/rtl/wre_outq.sv */
module wre_outq
    import wre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_push                 i_push,
    input  logic                  i_stall,
    output logic [OUTQ_CNT_W-1:0] o_count,
    output logic                  o_valid,
    output t_result               o_result
);

    t_result               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count;

    logic pop;

    assign o_valid  = r_count != '0;
    assign pop      = o_valid && !i_stall;
    assign o_count  = r_count;
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUTQ_PTR_W'(i_push.num);
            r_rd_ptr <= r_rd_ptr + OUTQ_PTR_W'(pop);
            r_count  <= r_count + OUTQ_CNT_W'(i_push.num) - OUTQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num[1]) begin
            r_mem[r_wr_ptr + OUTQ_PTR_W'(1)] <= i_push.second;
        end
    end

endmodule

/* hw/rtl/wre_checker.sv */
`include "wall_run_extractor_top_assert.svh"

module wre_checker
    import wre_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_is_vertical,
    input logic [DIM_W-1:0]     o_coord_x,
    input logic [DIM_W-1:0]     o_coord_y,
    input logic [CNT_W-1:0]     o_run_length,
    input logic                 o_last_of_item
);

    // A horizontal run ends at coord_x, so it cannot be longer than coord_x.
    `WRE_ASSERT_NOW(a_horiz_fits, o_out_valid && !o_is_vertical, o_run_length <= o_coord_x && o_run_length != '0 && o_coord_y != '0)

    // A vertical run ends at coord_y, so it cannot be longer than coord_y.
    `WRE_ASSERT_NOW(a_vert_fits, o_out_valid && o_is_vertical, o_run_length <= o_coord_y && o_run_length != '0 && o_coord_x != '0)

    // The first of two results from one tile is horizontal and the second vertical.
    `WRE_ASSERT_NEXT(a_pair_order, o_out_valid && !i_out_stall && !o_last_of_item, o_out_valid && o_is_vertical && o_last_of_item)

    // A stalled result holds.
    `WRE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_coord_x) && $stable(o_coord_y) && $stable(o_run_length) && $stable(o_is_vertical))

endmodule

bind wall_run_extractor_top wre_checker u_wre_checker (.*);

/* tb/wall_run_extractor_checker.sv */
module wall_run_extractor_checker
    import wre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_is_wall,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_is_vertical,
    input  logic [DIM_W-1:0]     i_coord_x,
    input  logic [DIM_W-1:0]     i_coord_y,
    input  logic [CNT_W-1:0]     i_run_length,
    input  logic                 i_last_of_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [CNT_W-1:0] min_run_reg;

    int unsigned col_at;
    int unsigned row_at;
    int unsigned row_run;
    int unsigned column_runs [MAX_WIDTH];

    t_result expected_runs[$];
    t_result tile_runs[$];
    int      fail_count = 0;

    task automatic report(input string msg);
        $display("[%0t] run mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic restart_frame();
        col_at  = 0;
        row_at  = 0;
        row_run = 0;
        foreach (column_runs[i]) column_runs[i] = 0;
    endtask

    task automatic add_run(input bit vert, input int unsigned x, input int unsigned y,
                           input int unsigned len);
        int unsigned need;
        t_result     found;
        need = (min_run_reg == '0) ? 1 : min_run_reg;
        if (len != 0 && len >= need) begin
            found.is_vertical  = vert;
            found.coord_x      = DIM_W'(x);
            found.coord_y      = DIM_W'(y);
            found.run_length   = CNT_W'(len);
            found.last_of_item = 1'b0;
            tile_runs = {tile_runs, found};
        end
    endtask

    // Works out the runs that one tile completes and queues them in order.
    task automatic predict_tile(input logic wall);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned len;
        bit          row_end;
        bit          last_row;
        t_result     found;
        w = (width_reg == '0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == '0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        c = col_at;
        r = row_at;
        row_end  = (c + 1) >= w;
        last_row = (r + 1) >= h;
        tile_runs.delete();

        if (wall) begin
            len = row_run + 1;
            if (row_end) begin
                add_run(1'b0, c + 1, r + 1, len);
                row_run = 0;
            end else begin
                row_run = len;
            end
        end else begin
            if (row_run > 0) add_run(1'b0, c, r + 1, row_run);
            row_run = 0;
        end

        if (wall) begin
            len = column_runs[c % MAX_WIDTH] + 1;
            if (last_row) begin
                add_run(1'b1, c + 1, r + 1, len);
                column_runs[c % MAX_WIDTH] = 0;
            end else begin
                column_runs[c % MAX_WIDTH] = len;
            end
        end else begin
            if (column_runs[c % MAX_WIDTH] > 0) begin
                add_run(1'b1, c + 1, r, column_runs[c % MAX_WIDTH]);
            end
            column_runs[c % MAX_WIDTH] = 0;
        end

        if (row_end) begin
            if (last_row) begin
                restart_frame();
            end else begin
                col_at  = 0;
                row_at  = r + 1;
                row_run = 0;
            end
        end else begin
            col_at = c + 1;
        end

        foreach (tile_runs[i]) begin
            found = tile_runs[i];
            found.last_of_item = (i == tile_runs.size() - 1);
            expected_runs = {expected_runs, found};
        end
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] want);
        if (got !== want) begin
            report($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_runs.size() == 0) begin
            report($sformatf("unexpected run: vertical %0b x %0d y %0d length %0d",
                             i_is_vertical, i_coord_x, i_coord_y, i_run_length));
        end else begin
            want = expected_runs.pop_front();
            check_field("is_vertical", 9'(i_is_vertical), 9'(want.is_vertical));
            check_field("coord_x", i_coord_x, want.coord_x);
            check_field("coord_y", i_coord_y, want.coord_y);
            check_field("run_length", i_run_length, want.run_length);
            check_field("last_of_item", 9'(i_last_of_item), 9'(want.last_of_item));
        end
    endtask

    // Handshakes are sampled before the edge updates anything, so the
    // order of processes within the time step does not matter.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg   = RST_MAP_WIDTH;
            height_reg  = RST_MAP_HEIGHT;
            min_run_reg = RST_MIN_RUN;
            restart_frame();
            expected_runs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAP_WIDTH: begin
                        width_reg = i_cfg_data;
                        restart_frame();
                    end
                    REG_MAP_HEIGHT: begin
                        height_reg = i_cfg_data;
                        restart_frame();
                    end
                    REG_MIN_RUN: begin
                        min_run_reg = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) predict_tile(i_is_wall);
        end
        o_pending    <= expected_runs.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/tb_wall_run_extractor_top.sv */
module tb_wall_run_extractor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wre_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT   = 5000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 is_wall   = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 is_vertical;
    logic [DIM_W-1:0]     coord_x;
    logic [DIM_W-1:0]     coord_y;
    logic [CNT_W-1:0]     run_length;
    logic                 last_of_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    int fail_count;
    int pending;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int stuck_count = 0;

    always #5ns clk = ~clk;

    wall_run_extractor_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_is_wall      (is_wall),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_is_vertical  (is_vertical),
        .o_coord_x      (coord_x),
        .o_coord_y      (coord_y),
        .o_run_length   (run_length),
        .o_last_of_item (last_of_item),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    wall_run_extractor_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_is_wall      (is_wall),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_is_vertical  (is_vertical),
        .i_coord_x      (coord_x),
        .i_coord_y      (coord_y),
        .i_run_length   (run_length),
        .i_last_of_item (last_of_item),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            stuck_count <= 0;
        end else if (stuck_count >= STUCK_LIMIT) begin
            $display("[wall_run_extractor_top] ERROR");
            $finish;
        end else begin
            stuck_count <= stuck_count + 1;
        end
    end

    task automatic set_idling(input int sender, input int receiver);
        idle_pct  = sender;
        stall_pct = receiver;
    endtask

    // Offers one tile and returns at the edge that accepts the request.
    task automatic send_tile(input logic wall);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            is_wall  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        is_wall  <= wall;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_pattern(input logic [31:0] pattern, input int count);
        for (int i = count - 1; i >= 0; i--) send_tile(pattern[i]);
    endtask

    task automatic send_random(input int count, input int wall_pct);
        repeat (count) send_tile($urandom_range(99) < wall_pct);
    endtask

    // A tile that completes no run may still be in flight when the last
    // expected run arrives, so keep clocking for SETTLE_CYCLES after that.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-tile frame with zero geometry and a zero minimum: a wall tile
        // closes a horizontal and a vertical run of one at once.
        write_reg(REG_MIN_RUN, '0);
        write_reg(REG_MAP_WIDTH, '0);
        write_reg(REG_MAP_HEIGHT, '0);
        send_pattern(32'b101, 3);
        wait_idle();

        write_reg(REG_UNUSED, '1);
        write_reg(REG_MAP_WIDTH, 9'd3);
        write_reg(REG_MAP_HEIGHT, 9'd3);
        write_reg(REG_MIN_RUN, 9'd1);
        send_pattern(32'b110_011_111, 9);
        wait_idle();

        // A new minimum keeps the frame going; a new width restarts it.
        write_reg(REG_MIN_RUN, 9'd2);
        send_pattern(32'b1011, 4);
        wait_idle();
        write_reg(REG_MAP_WIDTH, 9'd4);
        send_pattern(32'b111110, 6);
        wait_idle();

        set_idling(0, 0);
        write_reg(REG_MAP_WIDTH, 9'd8);
        write_reg(REG_MAP_HEIGHT, 9'd6);
        write_reg(REG_MIN_RUN, RST_MIN_RUN);
        send_random(200, 70);
        wait_idle();

        set_idling(59, 0);
        write_reg(REG_MAP_WIDTH, 9'd5);
        write_reg(REG_MAP_HEIGHT, 9'd4);
        write_reg(REG_MIN_RUN, 9'd2);
        send_random(200, 60);
        wait_idle();

        // Single column of the tallest map, all walls.
        set_idling(0, 59);
        write_reg(REG_MAP_WIDTH, '0);
        write_reg(REG_MAP_HEIGHT, 9'd511);
        write_reg(REG_MIN_RUN, 9'd1);
        send_random(256, 100);
        wait_idle();

        // Widest row, all walls, then a minimum no run can reach.
        set_idling(11, 11);
        write_reg(REG_MAP_WIDTH, 9'd511);
        write_reg(REG_MAP_HEIGHT, 9'd256);
        write_reg(REG_MIN_RUN, 9'd256);
        send_random(256, 100);
        wait_idle();
        write_reg(REG_MIN_RUN, 9'd511);
        send_random(50, 90);
        wait_idle();

        set_idling(0, 0);
        write_reg(REG_MAP_WIDTH, 9'd7);
        write_reg(REG_MAP_HEIGHT, 9'd9);
        write_reg(REG_MIN_RUN, 9'd1);
        send_random(300, 50);
        wait_idle();

        set_idling(59, 0);
        write_reg(REG_MAP_WIDTH, 9'd16);
        write_reg(REG_MAP_HEIGHT, 9'd16);
        write_reg(REG_MIN_RUN, 9'd4);
        send_random(400, 75);
        wait_idle();

        set_idling(0, 59);
        write_reg(REG_MAP_WIDTH, 9'd3);
        write_reg(REG_MAP_HEIGHT, 9'd2);
        write_reg(REG_MIN_RUN, 9'd2);
        send_random(200, 80);
        wait_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("[wall_run_extractor_top] OK");
        end else begin
            $display("[wall_run_extractor_top] ERROR");
        end
        $finish;
    end

endmodule
